@@ hw/rtl/mctm_pkg.sv @@
package mctm_pkg;

    localparam int RATE_W      = 27;
    localparam int CPB_W       = 7;
    localparam int TICK_W      = 32;
    localparam int TEMPO_W     = 16;
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 32;

    // 60 * rate needs six more bits than the rate itself
    localparam int SCALED_W = RATE_W + 6;

    localparam int AVERAGE_DEPTH_DEF = 32;
    localparam int FRACTION_BITS_DEF = 4;

    // beat queue depth, power of two
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0]      TIMING_CLOCK = 8'hF8;
    localparam logic [RATE_W-1:0]      RATE_RESET   = 27'd1000000;
    localparam logic [CPB_W-1:0]       CPB_RESET    = 7'd24;
    localparam logic [TEMPO_W-1:0]     TEMPO_MAX    = 16'hFFFF;

    localparam logic [CFG_INDEX_W-1:0] CFG_TICK_RATE       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCKS_PER_BEAT = 8'd1;

    typedef logic [TICK_W-1:0] ticks_t;

    // one finished beat handed from the front to the back
    typedef struct packed {
        logic   valid;
        ticks_t ticks;
    } beat_t;

    function automatic logic [SCALED_W-1:0] times_sixty(input logic [RATE_W-1:0] rate);
        logic [SCALED_W-1:0] wide;
        wide = SCALED_W'(rate);
        return (wide << 6) - (wide << 2);
    endfunction

endpackage

@@ hw/rtl/mctm_ram.sv @@
module mctm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/mctm_fifo.sv @@
module mctm_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  mctm_pkg::beat_t push,
    output logic            full,
    output mctm_pkg::beat_t head,
    input  logic            pop
);

    import mctm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    ticks_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.ticks = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.ticks;
        end
    end

endmodule

@@ hw/rtl/mctm_front.sv @@
module mctm_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        action,
    input  logic [mctm_pkg::BYTE_W-1:0] midi_byte,
    input  logic [mctm_pkg::CPB_W-1:0]  clocks_per_beat,
    input  logic                        queue_full,
    output mctm_pkg::beat_t             push
);

    import mctm_pkg::*;

    ticks_t           elapsed_reg;
    ticks_t           elapsed_next;
    logic [CPB_W-1:0] clock_count_reg;
    logic [CPB_W-1:0] clock_count_next;
    logic [CPB_W-1:0] clock_inc;
    logic             accept;
    logic             is_clock;
    logic             beat_end;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign clock_inc = clock_count_reg + 1'b1;
    assign is_clock  = action && (midi_byte == TIMING_CLOCK);
    assign beat_end  = is_clock && !(clock_inc < clocks_per_beat);

    assign push.valid = accept && beat_end;
    assign push.ticks = elapsed_reg;

    always_comb
    begin
        elapsed_next     = elapsed_reg;
        clock_count_next = clock_count_reg;
        if (accept)
        begin
            if (!action)
            begin
                if (elapsed_reg != '1)
                begin
                    elapsed_next = elapsed_reg + 1'b1;
                end
            end
            else if (beat_end)
            begin
                elapsed_next     = '0;
                clock_count_next = '0;
            end
            else if (is_clock)
            begin
                clock_count_next = clock_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg     <= '0;
            clock_count_reg <= '0;
        end
        else
        begin
            elapsed_reg     <= elapsed_next;
            clock_count_reg <= clock_count_next;
        end
    end

endmodule

@@ hw/rtl/mctm_div.sv @@
module mctm_div #(
    parameter int NUM_W = 37
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [NUM_W-1:0]            dividend,
    input  logic [mctm_pkg::TICK_W-1:0] divisor,
    output logic                        done,
    output logic [NUM_W-1:0]            quotient
);

    import mctm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    ticks_t           rem_reg;
    ticks_t           divisor_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [TICK_W:0]  trial;
    logic [TICK_W:0]  diff;
    logic             fits;

    // restoring divide, one quotient bit per cycle; a zero divisor gives all ones
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});
    assign diff  = trial - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hw/rtl/mctm_back.sv @@
module mctm_back #(
    parameter int AVERAGE_DEPTH = mctm_pkg::AVERAGE_DEPTH_DEF,
    parameter int FRACTION_BITS = mctm_pkg::FRACTION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [mctm_pkg::RATE_W-1:0]  tick_rate_hz,
    input  mctm_pkg::beat_t              head,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mctm_pkg::TEMPO_W-1:0] tempo_q4,
    output logic [mctm_pkg::TEMPO_W-1:0] average_tempo_q4,
    output logic [mctm_pkg::TICK_W-1:0]  beat_ticks
);

    import mctm_pkg::*;

    localparam int NUM_W = SCALED_W + FRACTION_BITS;
    localparam int PTR_W = $clog2(AVERAGE_DEPTH);
    localparam int SUM_W = TEMPO_W + PTR_W;

    // floor(sum / AVERAGE_DEPTH) as (sum * RECIP) >> RECIP_SHIFT, exact for any SUM_W-bit sum
    localparam int          RECIP_SHIFT = SUM_W + PTR_W;
    localparam int          RECIP_W     = SUM_W + 1;
    localparam int          PROD_W      = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL  = ((64'd1 << RECIP_SHIFT) + 64'(AVERAGE_DEPTH - 1))
                                          / 64'(AVERAGE_DEPTH);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_TEMPO = 4'b0010,
        S_AVG   = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [PTR_W-1:0]         ptr_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         sum_next;
    logic [AVERAGE_DEPTH-1:0] valid_reg;
    ticks_t                   ticks_reg;
    logic [TEMPO_W-1:0]       tempo_reg;
    logic [TEMPO_W-1:0]       avg_reg;
    logic                     out_valid_reg;
    logic [TEMPO_W-1:0]       tempo_out_reg;
    logic [TEMPO_W-1:0]       avg_out_reg;
    ticks_t                   ticks_out_reg;

    logic                     div_start;
    logic [NUM_W-1:0]         div_dividend;
    ticks_t                   div_divisor;
    logic                     div_done;
    logic [NUM_W-1:0]         div_quotient;
    logic [TEMPO_W-1:0]       tempo_sat;
    logic [TEMPO_W-1:0]       ram_rdata;
    logic [TEMPO_W-1:0]       old_entry;
    logic [PROD_W-1:0]        avg_product;
    logic                     tempo_done;
    logic                     ring_write;
    logic                     out_load;

    assign pop        = (state_reg == S_IDLE) && head.valid;
    assign tempo_done = (state_reg == S_TEMPO) && div_done;
    assign ring_write = tempo_done;
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    assign tempo_sat = (|div_quotient[NUM_W-1:TEMPO_W]) ? TEMPO_MAX
                                                         : div_quotient[TEMPO_W-1:0];
    // slots never written since reset read as zero
    assign old_entry = valid_reg[ptr_reg] ? ram_rdata : '0;
    assign sum_next  = sum_reg - SUM_W'(old_entry) + SUM_W'(tempo_sat);

    assign avg_product = PROD_W'(sum_reg) * PROD_W'(RECIP);

    assign div_start    = pop;
    assign div_dividend = NUM_W'(times_sixty(tick_rate_hz)) << FRACTION_BITS;
    assign div_divisor  = head.ticks;

    mctm_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    mctm_ram #(
        .WIDTH (TEMPO_W),
        .DEPTH (AVERAGE_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_write),
        .waddr (ptr_reg),
        .wdata (tempo_sat),
        .re    (pop),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    state_next = S_TEMPO;
                end
            end
            S_TEMPO:
            begin
                if (div_done)
                begin
                    state_next = S_AVG;
                end
            end
            S_AVG:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            sum_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (tempo_done)
            begin
                sum_reg            <= sum_next;
                valid_reg[ptr_reg] <= 1'b1;
                ptr_reg            <= (ptr_reg == PTR_W'(AVERAGE_DEPTH - 1)) ? '0
                                                                             : ptr_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ticks_reg <= head.ticks;
        end
        if (tempo_done)
        begin
            tempo_reg <= tempo_sat;
        end
        if (state_reg == S_AVG)
        begin
            avg_reg <= avg_product[RECIP_SHIFT +: TEMPO_W];
        end
        if (out_load)
        begin
            tempo_out_reg <= tempo_reg;
            avg_out_reg   <= avg_reg;
            ticks_out_reg <= ticks_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign tempo_q4         = tempo_out_reg;
    assign average_tempo_q4 = avg_out_reg;
    assign beat_ticks       = ticks_out_reg;

endmodule

@@ hw/rtl/midi_clock_tempo_meter.sv @@
// Ticks and non-beat bytes: one word per cycle while the beat queue is not full, no result.
// Beat-ending timing clock: pushed into the beat queue, then the back end pops it, runs the
// one-bit-per-cycle tempo divide, updates the ring average and registers the result word.
// Back end takes no new beat until its result word is loaded; two more beats queue in front
// of it, and the input stalls only while that queue is full.
// Reset (rst_n low, async) clears counters, queue, ring valid bits and config to defaults.
module midi_clock_tempo_meter #(
    parameter int AVERAGE_DEPTH = mctm_pkg::AVERAGE_DEPTH_DEF,
    parameter int FRACTION_BITS = mctm_pkg::FRACTION_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             action,
    input  logic [mctm_pkg::BYTE_W-1:0]      midi_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mctm_pkg::TEMPO_W-1:0]     tempo_q4,
    output logic [mctm_pkg::TEMPO_W-1:0]     average_tempo_q4,
    output logic [mctm_pkg::TICK_W-1:0]      beat_ticks,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mctm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mctm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import mctm_pkg::*;

    logic [RATE_W-1:0] tick_rate_reg;
    logic [CPB_W-1:0]  cpb_reg;
    beat_t             push;
    beat_t             head;
    logic              queue_full;
    logic              pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_rate_reg <= RATE_RESET;
            cpb_reg       <= CPB_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TICK_RATE:       tick_rate_reg <= cfg_data[RATE_W-1:0];
                CFG_CLOCKS_PER_BEAT: cpb_reg       <= cfg_data[CPB_W-1:0];
                default:             ;
            endcase
        end
    end

    mctm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .action          (action),
        .midi_byte       (midi_byte),
        .clocks_per_beat (cpb_reg),
        .queue_full      (queue_full),
        .push            (push)
    );

    mctm_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (queue_full),
        .head  (head),
        .pop   (pop)
    );

    mctm_back #(
        .AVERAGE_DEPTH (AVERAGE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .tick_rate_hz     (tick_rate_reg),
        .head             (head),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .tempo_q4         (tempo_q4),
        .average_tempo_q4 (average_tempo_q4),
        .beat_ticks       (beat_ticks)
    );

endmodule

@@ hw/rtl/mctm_checker.sv @@
module mctm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             action,
    input logic [mctm_pkg::BYTE_W-1:0]      midi_byte,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [mctm_pkg::TEMPO_W-1:0]     tempo_q4,
    input logic [mctm_pkg::TEMPO_W-1:0]     average_tempo_q4,
    input logic [mctm_pkg::TICK_W-1:0]      beat_ticks,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);

    import mctm_pkg::*;

    logic seen_clock_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_clock_reg <= 1'b0;
        end
        else if (in_valid && in_ready && action && (midi_byte == TIMING_CLOCK))
        begin
            seen_clock_reg <= 1'b1;
        end
    end

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tempo_q4)
            && $stable(average_tempo_q4) && $stable(beat_ticks))
        else $error("result word changed while stalled");

    // a result needs at least one timing clock since reset
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_clock_reg)
        else $error("result without any timing clock");

    // zero-tick beat saturates
    a_zero_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (beat_ticks == '0) |-> (tempo_q4 == TEMPO_MAX))
        else $error("zero-tick beat did not saturate");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind midi_clock_tempo_meter mctm_checker u_checker (.*);

@@ dv/tb_midi_clock_tempo_meter.sv @@
module tb_midi_clock_tempo_meter;
    timeunit 1ns;
    timeprecision 1ps;

    import mctm_pkg::*;

    localparam int AVG_DEPTH = AVERAGE_DEPTH_DEF;
    localparam int FRAC_BITS = FRACTION_BITS_DEF;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_BYTE = 1'b1;

    // indexes past the two registers, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LOW  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HIGH = 8'hFF;

    localparam int DRAIN_CYCLES   = 120;
    localparam int HOLD_OFF       = 600;
    localparam int TRAFFIC_TARGET = 450;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [TEMPO_W-1:0] tempo;
        logic [TEMPO_W-1:0] average;
        ticks_t             ticks;
    } beat_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   action;
    logic [BYTE_W-1:0]      midi_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic [TEMPO_W-1:0]     tempo_q4;
    logic [TEMPO_W-1:0]     average_tempo_q4;
    logic [TICK_W-1:0]      beat_ticks;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    midi_clock_tempo_meter DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .midi_byte        (midi_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .tempo_q4         (tempo_q4),
        .average_tempo_q4 (average_tempo_q4),
        .beat_ticks       (beat_ticks),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // tempo meter state, mirrored
    logic [RATE_W-1:0]  m_rate;
    logic [CPB_W-1:0]   m_cpb;
    ticks_t             m_elapsed;
    logic [CPB_W-1:0]   m_clocks;
    logic [TEMPO_W-1:0] m_ring [AVG_DEPTH];
    int unsigned        m_slot;
    int unsigned        m_sum;

    beat_result_t expected_beats[$];

    int  mismatch_count = 0;
    int  traffic_words  = 0;
    int  hold_cycles    = 0;
    int  rx_wait        = 0;
    bit  tx_idle        = 1'b0;
    bit  rx_idle        = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [TEMPO_W-1:0] tempo_of(input ticks_t ticks);
        logic [63:0] num;
        logic [63:0] q;
        if (ticks == '0)
            return TEMPO_MAX;
        num = (64'(m_rate) * 64'd60) << FRAC_BITS;
        q   = num / 64'(ticks);
        if (q > 64'(TEMPO_MAX))
            return TEMPO_MAX;
        return q[TEMPO_W-1:0];
    endfunction

    function automatic void meter_step(input logic act, input logic [BYTE_W-1:0] data);
        beat_result_t r;
        if (act == ACT_TICK)
        begin
            if (m_elapsed != '1)
                m_elapsed = m_elapsed + 1'b1;
        end
        else if (data == TIMING_CLOCK)
        begin
            m_clocks = m_clocks + 1'b1;
            if (m_clocks >= m_cpb)
            begin
                r.tempo = tempo_of(m_elapsed);
                m_sum = m_sum - m_ring[m_slot] + r.tempo;
                m_ring[m_slot] = r.tempo;
                m_slot = (m_slot + 1) % AVG_DEPTH;
                r.average = TEMPO_W'(m_sum / AVG_DEPTH);
                r.ticks = m_elapsed;
                expected_beats.push_back(r);
                m_elapsed = '0;
                m_clocks  = '0;
            end
        end
    endfunction

    function automatic void note_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t ERROR: %s", $realtime, msg);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp,
                                        input logic [31:0] act);
        if (exp !== act)
            note_error($sformatf("%s expected %0d got %0d", name, exp, act));
    endfunction

    // result side: ready with random gaps, plus a long hold-off on request
    initial
    begin : result_sink
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin : result_monitor
        beat_result_t exp;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                    note_error($sformatf("unexpected word tempo=%0d avg=%0d ticks=%0d",
                                         tempo_q4, average_tempo_q4, beat_ticks));
                else
                begin
                    exp = expected_beats.pop_front();
                    check_field("tempo_q4", 32'(exp.tempo), 32'(tempo_q4));
                    check_field("average_tempo_q4", 32'(exp.average), 32'(average_tempo_q4));
                    check_field("beat_ticks", exp.ticks, beat_ticks);
                end
                rx_wait = rx_idle ? $urandom_range(0, 11) : 0;
            end
        end
    end

    task automatic send_word(input logic act, input logic [BYTE_W-1:0] data);
        int gap;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        action    <= act;
        midi_byte <= data;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        meter_step(act, data);
        traffic_words++;
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_word(ACT_TICK, BYTE_W'($urandom));
    endtask

    task automatic send_clocks(input int count);
        repeat (count) send_word(ACT_BYTE, TIMING_CLOCK);
    endtask

    // stop offering, let every pending beat come out, then give the back end time to settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        if (idx == CFG_TICK_RATE)
            m_rate = data[RATE_W-1:0];
        else if (idx == CFG_CLOCKS_PER_BEAT)
            m_cpb = data[CPB_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_meter(input logic [CFG_DATA_W-1:0] rate_data,
                             input logic [CFG_DATA_W-1:0] cpb_data);
        wait_idle();
        write_reg(CFG_TICK_RATE, rate_data);
        write_reg(CFG_CLOCKS_PER_BEAT, cpb_data);
    endtask

    // reset rate and beat length; short beats, so the tempo saturates at the reset rate
    task automatic test_reset_defaults();
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        send_ticks(15 + $urandom_range(0, 10));
        send_clocks(CPB_RESET);
        send_ticks(3);
        send_clocks(CPB_RESET);
    endtask

    task automatic test_ignored_bytes();
        tx_idle = 1'b1;
        set_meter(32'd1000, 32'd1);
        send_word(ACT_BYTE, 8'h00);
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_BYTE, 8'hF7);
        send_word(ACT_BYTE, 8'hF9);
        send_word(ACT_TICK, TIMING_CLOCK);
        send_word(ACT_TICK, 8'hFF);
        // two ticks at this rate saturate the tempo
        send_clocks(1);
    endtask

    task automatic test_zero_tick_beat();
        send_clocks(1);
        send_ticks(15);
        send_clocks(1);
    endtask

    task automatic test_zero_settings();
        // upper data bits set, masked to zero beat length: every clock ends a beat
        set_meter(32'd1000, 32'hFFFF_FF80);
        send_ticks(4);
        send_clocks(2);
        wait_idle();
        write_reg(CFG_TICK_RATE, 32'hF800_0000);
        send_ticks(1);
        send_clocks(2);
    endtask

    task automatic test_rate_extremes();
        set_meter(32'hFFFF_FFFF, 32'd1);
        send_ticks(2);
        send_clocks(1);
        set_meter(32'd1, 32'd1);
        send_ticks(3);
        send_clocks(1);
    endtask

    task automatic test_unused_index();
        wait_idle();
        write_reg(CFG_UNUSED_LOW, 32'd5);
        write_reg(CFG_UNUSED_HIGH, 32'h0000_0000);
        send_ticks(2);
        send_clocks(1);
    endtask

    // sink stalls long while beats keep coming, the beat queue fills and blocks the input
    task automatic test_hold_off();
        set_meter(32'd1000, 32'd1);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_cycles = HOLD_OFF;
        repeat (16)
        begin
            send_ticks($urandom_range(0, 3));
            send_clocks(1);
        end
    endtask

    task automatic test_long_beats();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        set_meter(32'd2000, 32'd96);
        send_ticks($urandom_range(3, 8));
        send_clocks(96);
        // 127 via masked data
        set_meter(32'd2000, 32'hFFFF_FFFF);
        send_ticks($urandom_range(1, 4));
        send_clocks(127);
    endtask

    task automatic random_phase();
        logic [RATE_W-1:0] rate;
        logic [CPB_W-1:0]  cpb;
        int beats;
        int clocks;
        int ticks;
        case ($urandom_range(0, 9))
            0:       rate = '0;
            1:       rate = 27'd1;
            2:       rate = '1;
            3:       rate = 27'd100000000;
            default: rate = 27'($urandom_range(16, 4000));
        endcase
        cpb = ($urandom_range(0, 5) == 0) ? CPB_W'($urandom_range(5, 12))
                                          : CPB_W'($urandom_range(0, 4));
        set_meter(($urandom & 32'hF800_0000) | 32'(rate), ($urandom & 32'hFFFF_FF80) | 32'(cpb));
        tx_idle = $urandom_range(0, 3) != 0;
        rx_idle = $urandom_range(0, 3) != 0;
        beats = $urandom_range(2, 6);
        repeat (beats)
        begin
            clocks = (m_cpb == 0) ? 1 : m_cpb;
            repeat (clocks)
            begin
                ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 8);
                send_ticks(ticks);
                // noise, sometimes a stray clock that breaks the beat
                if ($urandom_range(0, 7) == 0)
                    send_word(1'($urandom_range(0, 1)), BYTE_W'($urandom));
                send_clocks(1);
            end
        end
    endtask

    task automatic test_random_traffic();
        while (traffic_words < TRAFFIC_TARGET)
            random_phase();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        action    = ACT_TICK;
        midi_byte = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        m_rate    = RATE_RESET;
        m_cpb     = CPB_RESET;
        m_elapsed = '0;
        m_clocks  = '0;
        m_slot    = 0;
        m_sum     = 0;
        foreach (m_ring[i])
            m_ring[i] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_ignored_bytes();
        test_zero_tick_beat();
        test_zero_settings();
        test_rate_extremes();
        test_unused_index();
        test_hold_off();
        test_long_beats();
        test_random_traffic();

        wait_idle();
        if (expected_beats.size() != 0)
            note_error($sformatf("%0d beats never arrived", expected_beats.size()));
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/mctm_pkg.sv
hw/rtl/mctm_ram.sv
hw/rtl/mctm_fifo.sv
hw/rtl/mctm_front.sv
hw/rtl/mctm_div.sv
hw/rtl/mctm_back.sv
hw/rtl/midi_clock_tempo_meter.sv
hw/rtl/mctm_checker.sv
dv/tb_midi_clock_tempo_meter.sv
